[rtl/core/som_neighborhood_weight_assert.svh]
// assertion helpers used by the neighbourhood weight rtl
`ifndef SOM_NEIGHBORHOOD_WEIGHT_ASSERT_SVH
`define SOM_NEIGHBORHOOD_WEIGHT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SNW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SNW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/som_nw_pkg.sv]
package som_nw_pkg;

	// largest usable map side
	localparam logic [10:0] SIDE_MAX = 11'd1024;
	// log2(e) in q.16
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	// exponent clamp, 32.0 in q.16
	localparam logic [21:0] EXP_CLAMP = 22'h200000;
	// 1.0 in q0.16
	localparam logic [16:0] SCALE_ONE = 17'd65536;
	// pipeline lengths
	localparam int unsigned N_STEPS = 21;
	localparam int unsigned N_POW = 16;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TOPOLOGY = 3'd0,
		REG_MAP_COLUMNS = 3'd1,
		REG_MAP_ROWS = 3'd2,
		REG_RADIUS = 3'd3,
		REG_SCALING = 3'd4,
		REG_COMPACT = 3'd5,
		REG_KERNEL = 3'd6,
		REG_SPREAD = 3'd7
	} som_nw_reg_e;

	typedef struct packed {
		logic [1:0] topology;
		logic [10:0] map_columns;
		logic [10:0] map_rows;
		logic [18:0] neighborhood_radius;
		logic [16:0] weight_scaling;
		logic tail_cut;
		logic gaussian_kernel;
		logic [15:0] spread_coefficient;
	} som_nw_cfg_t;

	typedef struct packed {
		logic [9:0] winner_col;
		logic [9:0] winner_row;
		logic [9:0] node_col;
		logic [9:0] node_row;
	} som_nw_in_t;

	typedef struct packed {
		logic [18:0] grid_distance;
		logic [16:0] neighbor_weight;
		logic coord_error;
	} som_nw_out_t;

	// item state carried down the pipeline
	typedef struct packed {
		logic cerr;
		logic in_radius;
		logic sat;
		logic szero;
		logic dzero;
		logic [37:0] s_sq;
		logic [38:0] div_rem;
		logic [20:0] quo;
		logic [41:0] sq_v;
		logic [21:0] sq_rem;
		logic [20:0] root;
		logic [5:0] nexp;
		logic [15:0] frac;
		logic [32:0] pwr;
	} som_nw_pipe_t;

	typedef logic [15:0][31:0] pow_tab_t;

	// bitwise integer square root, elaboration use only
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bt;
		rem = v;
		res = '0;
		bt = 64'h4000_0000_0000_0000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// factors 2^-(2^b / 65536) in q0.32
	function automatic pow_tab_t build_pow_tab();
		pow_tab_t t;
		logic [63:0] r;
		r = isqrt64(64'h8000_0000_0000_0000);
		t[15] = r[31:0];
		for (int b = 15; b > 0; b--) begin
			r = isqrt64({t[b], 32'h0});
			t[b-1] = r[31:0];
		end
		return t;
	endfunction

	localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

[rtl/core/som_nw_front.sv]
module som_nw_front (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input som_nw_pkg::som_nw_cfg_t cfg,
	input logic item_valid,
	input som_nw_pkg::som_nw_in_t item,
	output logic pipe_valid,
	output som_nw_pkg::som_nw_pipe_t pipe
);
	import som_nw_pkg::*;

	typedef struct packed {
		logic [9:0] gap;
		logic [9:0] low;
	} gap_t;

	// axis distance, taking the wrapped way round when wrap is set and it is shorter
	function automatic gap_t axis_gap(input logic [9:0] a, input logic [9:0] b,
			input logic [10:0] size, input logic wrap);
		gap_t g;
		logic [9:0] lo;
		logic [9:0] hi;
		logic [11:0] sum;
		logic [11:0] alt;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		sum = {2'b0, lo} + {1'b0, size};
		alt = sum - {2'b0, hi};
		g.low = lo;
		g.gap = hi - lo;
		if (wrap && (sum >= {2'b0, hi}) && (alt < {2'b0, g.gap})) begin
			g.gap = alt[9:0];
		end
		return g;
	endfunction

	logic [10:0] cols;
	logic [10:0] rows;
	logic wrap;
	logic hex;
	gap_t gx;
	gap_t gy;
	logic [10:0] hq;
	logic [34:0] rc;
	logic cerr;

	logic v_s1;
	logic [10:0] hq_s1;
	logic [9:0] dy_s1;
	logic hex_s1;
	logic cerr_s1;
	logic [18:0] spread_s1;

	logic [21:0] hq2;
	logic [19:0] dy2;
	logic [21:0] dyk;

	logic v_s2;
	logic [22:0] d4_s2;
	logic [37:0] ssq_s2;
	logic [37:0] rsq_s2;
	logic szero_s2;
	logic cerr_s2;

	som_nw_pipe_t p3;

	// stage 1: axis gaps, hex shift, spread, coordinate check
	always_comb begin
		cols = (cfg.map_columns > SIDE_MAX) ? SIDE_MAX : cfg.map_columns;
		rows = (cfg.map_rows > SIDE_MAX) ? SIDE_MAX : cfg.map_rows;
		wrap = cfg.topology[0];
		hex = cfg.topology[1];
		gx = axis_gap(item.winner_col, item.node_col, cols, wrap);
		gy = axis_gap(item.winner_row, item.node_row, rows, wrap);
		hq = {gx.gap, 1'b0};
		if (hex && gy.gap[0]) begin
			if (gy.low[0]) begin
				hq = (gx.gap == '0) ? 11'd1 : ({gx.gap, 1'b0} - 11'd1);
			end else begin
				hq = {gx.gap, 1'b1};
			end
		end
		rc = {16'b0, cfg.neighborhood_radius} * {19'b0, cfg.spread_coefficient};
		cerr = ({1'b0, item.winner_col} >= cols) || ({1'b0, item.node_col} >= cols) ||
			({1'b0, item.winner_row} >= rows) || ({1'b0, item.node_row} >= rows);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			pipe_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			pipe_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hq_s1 <= hq;
			dy_s1 <= gy.gap;
			hex_s1 <= hex;
			cerr_s1 <= cerr;
			spread_s1 <= rc[34:16];
		end
	end

	// stage 2: squared distance and squared spread and radius
	always_comb begin
		hq2 = {11'b0, hq_s1} * {11'b0, hq_s1};
		dy2 = {10'b0, dy_s1} * {10'b0, dy_s1};
		dyk = hex_s1 ? ({2'b0, dy2} + {1'b0, dy2, 1'b0}) : {dy2, 2'b0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d4_s2 <= {1'b0, hq2} + {1'b0, dyk};
			ssq_s2 <= {19'b0, spread_s1} * {19'b0, spread_s1};
			rsq_s2 <= {19'b0, cfg.neighborhood_radius} * {19'b0, cfg.neighborhood_radius};
			szero_s2 <= (spread_s1 == '0);
			cerr_s2 <= cerr_s1;
		end
	end

	// stage 3: radius test, exponent saturation, divider and root set-up
	always_comb begin
		p3 = '0;
		p3.cerr = cerr_s2;
		p3.in_radius = ({1'b0, d4_s2, 14'b0} <= rsq_s2);
		p3.sat = ({7'b0, d4_s2, 8'b0} >= ssq_s2);
		p3.szero = szero_s2;
		p3.dzero = (d4_s2 == '0);
		p3.s_sq = ssq_s2;
		p3.div_rem = p3.sat ? 39'd0 : {8'b0, d4_s2, 8'b0};
		p3.sq_v = {5'b0, d4_s2, 14'b0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe <= p3;
		end
	end

endmodule

[rtl/core/som_nw_step.sv]
module som_nw_step (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic up_valid,
	input som_nw_pkg::som_nw_pipe_t up,
	output logic dn_valid,
	output som_nw_pkg::som_nw_pipe_t dn
);
	import som_nw_pkg::*;

	logic [38:0] r2x;
	logic [23:0] rem_t;
	logic [23:0] trial;
	som_nw_pipe_t p;

	// one quotient bit of the exponent division and one root bit of the distance
	always_comb begin
		p = up;
		r2x = {up.div_rem[37:0], 1'b0};
		if (r2x >= {1'b0, up.s_sq}) begin
			p.div_rem = r2x - {1'b0, up.s_sq};
			p.quo = {up.quo[19:0], 1'b1};
		end else begin
			p.div_rem = r2x;
			p.quo = {up.quo[19:0], 1'b0};
		end
		rem_t = {up.sq_rem, up.sq_v[41:40]};
		trial = {1'b0, up.root, 2'b01};
		if (rem_t >= trial) begin
			p.sq_rem = 22'(rem_t - trial);
			p.root = {up.root[19:0], 1'b1};
		end else begin
			p.sq_rem = rem_t[21:0];
			p.root = {up.root[19:0], 1'b0};
		end
		p.sq_v = {up.sq_v[39:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (adv) begin
			dn_valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dn <= p;
		end
	end

endmodule

[rtl/core/som_nw_pow.sv]
module som_nw_pow (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic [31:0] factor,
	input logic up_valid,
	input som_nw_pkg::som_nw_pipe_t up,
	output logic dn_valid,
	output som_nw_pkg::som_nw_pipe_t dn
);
	import som_nw_pkg::*;

	logic [63:0] prod;
	som_nw_pipe_t p;

	// apply the factor for the lowest remaining fraction bit
	always_comb begin
		p = up;
		prod = {32'b0, up.pwr[31:0]} * {32'b0, factor};
		if (up.frac[0]) begin
			p.pwr = up.pwr[32] ? {1'b0, factor} : {1'b0, prod[63:32]};
		end
		p.frac = {1'b0, up.frac[15:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (adv) begin
			dn_valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dn <= p;
		end
	end

endmodule

[rtl/core/som_nw_back.sv]
module som_nw_back (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input som_nw_pkg::som_nw_cfg_t cfg,
	input logic pipe_valid,
	input som_nw_pkg::som_nw_pipe_t pipe,
	output logic res_valid,
	output som_nw_pkg::som_nw_out_t res
);
	import som_nw_pkg::*;

	logic [32:0] ps;
	logic [33:0] gsum;

	logic v_s1;
	logic [16:0] gk_s1;
	logic [18:0] dist_s1;
	logic cerr_s1;
	logic inside_s1;
	logic szero_s1;
	logic dzero_s1;

	logic [16:0] scale;
	logic [33:0] wm;
	logic [16:0] gw;
	som_nw_out_t r;

	// power of two shift and rounding to q0.16
	always_comb begin
		ps = pipe.pwr >> pipe.nexp;
		gsum = {1'b0, ps} + 34'h8000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			res_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= pipe_valid;
			res_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gk_s1 <= gsum[32:16];
			dist_s1 <= pipe.root[18:0];
			cerr_s1 <= pipe.cerr;
			inside_s1 <= pipe.in_radius;
			szero_s1 <= pipe.szero;
			dzero_s1 <= pipe.dzero;
		end
	end

	// scaled weight and kernel selection
	always_comb begin
		scale = (cfg.weight_scaling > SCALE_ONE) ? SCALE_ONE : cfg.weight_scaling;
		wm = ({17'b0, gk_s1} * {17'b0, scale}) + 34'h8000;
		gw = wm[32:16];
		r.grid_distance = dist_s1;
		r.coord_error = cerr_s1;
		r.neighbor_weight = '0;
		if (cfg.gaussian_kernel) begin
			if (!cfg.tail_cut || inside_s1) begin
				if (szero_s1) begin
					r.neighbor_weight = dzero_s1 ? scale : 17'd0;
				end else begin
					r.neighbor_weight = gw;
				end
			end
		end else if (inside_s1) begin
			r.neighbor_weight = scale;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res <= r;
		end
	end

endmodule

[rtl/core/som_neighborhood_weight.sv]
// Self-organizing map neighbourhood weight. Each request carries the grid
// coordinates of the winning node and of the node being weighted; the result
// gives their map distance (Q11.8), the scaled Gaussian or bubble weight (Q0.16)
// and a flag for coordinates outside the configured map. Planar, toroid and
// both hexagonal topologies are supported. The block is a 43-stage pipeline
// that takes one request per clock unless the result side stalls: 3 geometry
// stages, 21 stages that each produce one bit of the exponent quotient and one
// bit of the distance root, one base-conversion multiply, 16 power-of-two
// multiply stages and 2 output stages. A stall on the result side holds the
// whole pipeline. Configuration registers are written through the cfg port,
// which is always ready, and must only be written while no request is in
// flight.
module som_neighborhood_weight (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input som_nw_pkg::som_nw_in_t item,
	output logic result_valid,
	input logic result_stall,
	output som_nw_pkg::som_nw_out_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [18:0] cfg_data
);
	import som_nw_pkg::*;

	`include "som_neighborhood_weight_assert.svh"

	som_nw_cfg_t cfg_q;
	logic adv;

	logic step_v [N_STEPS+1];
	som_nw_pipe_t step_p [N_STEPS+1];
	logic pow_v [N_POW+1];
	som_nw_pipe_t pow_p [N_POW+1];

	logic [21:0] a_exp;
	logic [38:0] y_prod;
	som_nw_pipe_t pe;

	logic held;
	logic weight_ok;
	logic wt_bound;
	logic dist_ok;
	logic rad_wr;

	// whole pipeline moves unless the output is held
	assign adv = !(result_valid && result_stall);
	assign item_stall = !adv;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.topology <= 2'd0;
			cfg_q.map_columns <= 11'd16;
			cfg_q.map_rows <= 11'd16;
			cfg_q.neighborhood_radius <= 19'd256;
			cfg_q.weight_scaling <= 17'd65536;
			cfg_q.tail_cut <= 1'b0;
			cfg_q.gaussian_kernel <= 1'b1;
			cfg_q.spread_coefficient <= 16'd32768;
		end else if (cfg_valid && cfg_ready) begin
			unique case (som_nw_reg_e'(cfg_index))
				REG_TOPOLOGY: cfg_q.topology <= cfg_data[1:0];
				REG_MAP_COLUMNS: cfg_q.map_columns <= cfg_data[10:0];
				REG_MAP_ROWS: cfg_q.map_rows <= cfg_data[10:0];
				REG_RADIUS: cfg_q.neighborhood_radius <= cfg_data;
				REG_SCALING: cfg_q.weight_scaling <= cfg_data[16:0];
				REG_COMPACT: cfg_q.tail_cut <= cfg_data[0];
				REG_KERNEL: cfg_q.gaussian_kernel <= cfg_data[0];
				REG_SPREAD: cfg_q.spread_coefficient <= cfg_data[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	som_nw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.cfg(cfg_q),
		.item_valid(item_valid),
		.item(item),
		.pipe_valid(step_v[0]),
		.pipe(step_p[0])
	);

	// divider and square root steps
	for (genvar k = 0; k < N_STEPS; k++) begin : g_step
		som_nw_step u_step (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.up_valid(step_v[k]),
			.up(step_p[k]),
			.dn_valid(step_v[k+1]),
			.dn(step_p[k+1])
		);
	end

	// exponent to base two: integer part and fraction
	always_comb begin
		a_exp = step_p[N_STEPS].sat ? EXP_CLAMP : {1'b0, step_p[N_STEPS].quo};
		y_prod = {17'b0, a_exp} * {22'b0, LOG2E_Q16};
		pe = step_p[N_STEPS];
		pe.nexp = y_prod[37:32];
		pe.frac = y_prod[31:16];
		pe.pwr = 33'h1_0000_0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pow_v[0] <= 1'b0;
		end else if (adv) begin
			pow_v[0] <= step_v[N_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pow_p[0] <= pe;
		end
	end

	// fractional power of two, one fraction bit a stage
	for (genvar k = 0; k < N_POW; k++) begin : g_pow
		som_nw_pow u_pow (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.factor(POW_TAB[k]),
			.up_valid(pow_v[k]),
			.up(pow_p[k]),
			.dn_valid(pow_v[k+1]),
			.dn(pow_p[k+1])
		);
	end

	som_nw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.cfg(cfg_q),
		.pipe_valid(pow_v[N_POW]),
		.pipe(pow_p[N_POW]),
		.res_valid(result_valid),
		.res(result)
	);

	// terms for the checks below
	assign held = result_valid && result_stall;
	assign weight_ok = result.neighbor_weight <= SCALE_ONE;
	assign wt_bound = result_valid && (result.neighbor_weight != '0) &&
		(!cfg_q.gaussian_kernel || cfg_q.tail_cut);
	assign dist_ok = result.grid_distance <= cfg_q.neighborhood_radius;
	assign rad_wr = cfg_valid && cfg_ready && (cfg_index == REG_RADIUS);

	`SNW_ASSERT_IMPLIES(a_stall_back, held, item_stall, "output held, input open")
	`SNW_ASSERT_IMPLIES(a_weight_range, result_valid, weight_ok, "weight above one")
	`SNW_ASSERT_IMPLIES(a_support, wt_bound, dist_ok, "nonzero weight outside the radius")
	`SNW_ASSERT_NEXT(a_cfg_radius, rad_wr, cfg_q.neighborhood_radius == $past(cfg_data), "radius lost")

endmodule
